>>> rtl/i2cbm_pkg.sv
// Package for the I2C bus master: beat payload types, opcodes, bit-index and register-address constants.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package i2cbm_pkg;

   // Command opcodes carried in a request beat.
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_STOP  = 3'd4;

   // Bit positions within a byte transfer; position eight is the acknowledge bit.
   localparam logic [3:0] ACK_BIT_INDEX = 4'd8;

   // Byte addresses of the configuration registers.
   localparam logic [2:0] ADDR_HI_TICKS = 3'd0;
   localparam logic [2:0] ADDR_SETUP    = 3'd4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [6:0] address;
      logic       read_not_write;
      logic [7:0] data_byte;
      logic       last_byte;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_release;
      logic       busy_res;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       nack;
      logic       cmd_done;
      logic       cmd_error;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/i2cbm_if.sv
// Valid/ready channel interfaces for the request and response beats of the I2C bus master.
// Depends on i2cbm_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface i2cbm_req_if;
   import i2cbm_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface i2cbm_rsp_if;
   import i2cbm_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/i2c_bus_master.sv
// Top level of the I2C bus master: input register, bus phase logic and response register.
// Depends on i2cbm_pkg and the channel interfaces in i2cbm_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Each request beat is one bus tick: it carries a command (tick, start with a 7-bit address
// and direction, write byte, read byte, stop) and the sampled SDA level, and it yields exactly
// one response beat with the SCL level, the open-drain SDA control (1 releases, 0 pulls low)
// and the status flags for that tick. The block takes one beat per clock while the response
// side keeps taking beats; a beat is registered in the input register and its response then
// in the response register, where it waits while the response side does not take it. Every
// bit on the bus lasts (1 + setup_ticks) low ticks plus the configured SCL high time in
// ticks (zero counts as one), and SDA is sampled on the last high tick.
// A command given while another is running, a start inside a transaction, a byte command
// outside a transaction or after a NACK, a stop outside a transaction, and unknown opcodes
// are all rejected with cmd_error and change nothing. A NACK stays flagged until stop.
// Configuration registers are the SCL high time at byte address 0 and setup_ticks at 4;
// write them only while no command is running.
module i2c_bus_master (
   input  wire logic        clock,
   input  wire logic        reset,
   i2cbm_req_if.sink        req_bus,
   i2cbm_rsp_if.source      rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   import i2cbm_pkg::*;

   typedef enum logic [9:0] {
      M_IDLE    = 10'b00_0000_0001,
      M_START_A = 10'b00_0000_0010,
      M_START_B = 10'b00_0000_0100,
      M_TX_LO   = 10'b00_0000_1000,
      M_TX_HI   = 10'b00_0001_0000,
      M_RX_LO   = 10'b00_0010_0000,
      M_RX_HI   = 10'b00_0100_0000,
      M_STOP_A  = 10'b00_1000_0000,
      M_STOP_B  = 10'b01_0000_0000,
      M_STOP_C  = 10'b10_0000_0000
   } mode_type;

   // Configuration registers.
   logic [7:0] hi_ticks_ff;
   logic [7:0] setup_ff;

   // Input register holding one request beat.
   logic            s1_valid_ff;
   req_payload_type s1_ff;

   // Bus state.
   mode_type   mode_ff,  mode_in;
   logic [3:0] bit_ff,   bit_in;
   logic [7:0] tick_ff,  tick_in;
   logic [7:0] shift_ff, shift_in;
   logic       trans_ff, trans_in;
   logic       nack_ff,  nack_in;
   logic       final_ff, final_in;

   // Response register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic out_open;
   logic fire;

   // The response register can take a new beat when empty or being drained this cycle.
   assign out_open      = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = s1_valid_ff && out_open;
   assign req_bus.ready = !s1_valid_ff || out_open;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // APB register port, always ready; low address bits are ignored.
   logic cfg_write;
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == ADDR_SETUP[2]) begin
         prdata[7:0] = setup_ff;
      end else begin
         prdata[7:0] = hi_ticks_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ticks_ff <= 8'd10;
         setup_ff    <= 8'd0;
      end else if (cfg_write) begin
         if (paddr[2] == ADDR_SETUP[2]) begin
            setup_ff <= pwdata[7:0];
         end else begin
            hi_ticks_ff <= pwdata[7:0];
         end
      end
   end

   // Per-tick state update. The command is decoded first (it may enter a new phase with
   // counters cleared), then the phase that results drives the bus for this same tick.
   mode_type   mode_a;
   logic [3:0] bit_a;
   logic [7:0] tick_a;
   logic [7:0] shift_a;
   logic       trans_a;
   logic       nack_a;
   logic       final_a;
   logic       err;
   logic [7:0] high_last;
   logic       low_end;
   logic       high_end;
   logic       data_bit;
   logic [7:0] tick_inc;

   always_comb begin
      mode_a  = mode_ff;
      bit_a   = bit_ff;
      tick_a  = tick_ff;
      shift_a = shift_ff;
      trans_a = trans_ff;
      nack_a  = nack_ff;
      final_a = final_ff;
      err     = 1'b0;

      if (s1_ff.opcode != OP_TICK) begin
         if (mode_ff != M_IDLE) begin
            err = 1'b1;
         end else begin
            unique case (s1_ff.opcode)
               OP_START: begin
                  if (trans_ff) begin
                     err = 1'b1;
                  end else begin
                     shift_a = {s1_ff.address, s1_ff.read_not_write};
                     trans_a = 1'b1;
                     nack_a  = 1'b0;
                     mode_a  = M_START_A;
                     tick_a  = 8'd0;
                     bit_a   = 4'd0;
                  end
               end
               OP_WRITE: begin
                  if (!trans_ff || nack_ff) begin
                     err = 1'b1;
                  end else begin
                     shift_a = s1_ff.data_byte;
                     mode_a  = M_TX_LO;
                     tick_a  = 8'd0;
                     bit_a   = 4'd0;
                  end
               end
               OP_READ: begin
                  if (!trans_ff || nack_ff) begin
                     err = 1'b1;
                  end else begin
                     shift_a = 8'd0;
                     final_a = s1_ff.last_byte;
                     mode_a  = M_RX_LO;
                     tick_a  = 8'd0;
                     bit_a   = 4'd0;
                  end
               end
               OP_STOP: begin
                  if (!trans_ff) begin
                     err = 1'b1;
                  end else begin
                     mode_a = M_STOP_A;
                     tick_a = 8'd0;
                     bit_a  = 4'd0;
                  end
               end
               default: begin
                  err = 1'b1;
               end
            endcase
         end
      end
   end

   always_comb begin
      high_last = (hi_ticks_ff == 8'd0) ? 8'd0 : hi_ticks_ff - 8'd1;
      low_end   = tick_a >= setup_ff;
      high_end  = tick_a >= high_last;
      data_bit  = bit_a < ACK_BIT_INDEX;
      tick_inc  = tick_a + 8'd1;

      mode_in  = mode_a;
      bit_in   = bit_a;
      tick_in  = tick_a;
      shift_in = shift_a;
      trans_in = trans_a;
      nack_in  = nack_a;
      final_in = final_a;

      rsp_in             = '0;
      rsp_in.scl_out     = 1'b1;
      rsp_in.sda_release = 1'b1;
      rsp_in.cmd_error   = err;

      unique case (mode_a)
         M_START_A: begin
            rsp_in.sda_release = 1'b0;
            if (low_end) begin
               tick_in = 8'd0;
               mode_in = M_START_B;
            end else begin
               tick_in = tick_inc;
            end
         end
         M_START_B: begin
            rsp_in.scl_out     = 1'b0;
            rsp_in.sda_release = 1'b0;
            if (low_end) begin
               tick_in = 8'd0;
               bit_in  = 4'd0;
               mode_in = M_TX_LO;
            end else begin
               tick_in = tick_inc;
            end
         end
         M_TX_LO: begin
            rsp_in.scl_out     = 1'b0;
            rsp_in.sda_release = data_bit ? shift_a[7] : 1'b1;
            if (low_end) begin
               tick_in = 8'd0;
               mode_in = M_TX_HI;
            end else begin
               tick_in = tick_inc;
            end
         end
         M_TX_HI: begin
            rsp_in.sda_release = data_bit ? shift_a[7] : 1'b1;
            if (high_end) begin
               tick_in = 8'd0;
               if (data_bit) begin
                  shift_in = {shift_a[6:0], 1'b0};
                  bit_in   = bit_a + 4'd1;
                  mode_in  = M_TX_LO;
               end else begin
                  // Acknowledge bit: a released SDA from the target is a NACK.
                  if (s1_ff.sda_in) begin
                     nack_in = 1'b1;
                  end
                  bit_in          = 4'd0;
                  mode_in         = M_IDLE;
                  rsp_in.cmd_done = 1'b1;
               end
            end else begin
               tick_in = tick_inc;
            end
         end
         M_RX_LO: begin
            rsp_in.scl_out     = 1'b0;
            rsp_in.sda_release = data_bit ? 1'b1 : final_a;
            if (low_end) begin
               tick_in = 8'd0;
               mode_in = M_RX_HI;
            end else begin
               tick_in = tick_inc;
            end
         end
         M_RX_HI: begin
            rsp_in.sda_release = data_bit ? 1'b1 : final_a;
            if (high_end) begin
               tick_in = 8'd0;
               if (data_bit) begin
                  shift_in = {shift_a[6:0], s1_ff.sda_in};
                  bit_in   = bit_a + 4'd1;
                  mode_in  = M_RX_LO;
               end else begin
                  rsp_in.rx_byte  = shift_a;
                  rsp_in.rx_valid = 1'b1;
                  bit_in          = 4'd0;
                  mode_in         = M_IDLE;
                  rsp_in.cmd_done = 1'b1;
               end
            end else begin
               tick_in = tick_inc;
            end
         end
         M_STOP_A: begin
            rsp_in.scl_out     = 1'b0;
            rsp_in.sda_release = 1'b0;
            if (low_end) begin
               tick_in = 8'd0;
               mode_in = M_STOP_B;
            end else begin
               tick_in = tick_inc;
            end
         end
         M_STOP_B: begin
            rsp_in.sda_release = 1'b0;
            if (low_end) begin
               tick_in = 8'd0;
               mode_in = M_STOP_C;
            end else begin
               tick_in = tick_inc;
            end
         end
         M_STOP_C: begin
            if (low_end) begin
               tick_in         = 8'd0;
               bit_in          = 4'd0;
               mode_in         = M_IDLE;
               trans_in        = 1'b0;
               nack_in         = 1'b0;
               rsp_in.cmd_done = 1'b1;
            end else begin
               tick_in = tick_inc;
            end
         end
         default: begin
            // Idle: SCL is parked low inside a transaction and released outside one.
            rsp_in.scl_out = !trans_a;
            mode_in        = M_IDLE;
         end
      endcase

      rsp_in.busy_res = mode_in != M_IDLE;
      rsp_in.nack     = nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= M_IDLE;
         bit_ff       <= 4'd0;
         tick_ff      <= 8'd0;
         shift_ff     <= 8'd0;
         trans_ff     <= 1'b0;
         nack_ff      <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            bit_ff       <= bit_in;
            tick_ff      <= tick_in;
            shift_ff     <= shift_in;
            trans_ff     <= trans_in;
            nack_ff      <= nack_in;
            final_ff     <= final_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_ff <= req_bus.payload;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // A received byte is only reported together with the end of its read command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rx_valid |-> rsp_ff.cmd_done)
      else $error("rx_valid without cmd_done");

   // The NACK flag never survives outside a transaction.
   assert property (@(posedge clock) disable iff (reset)
      !trans_ff |-> !nack_ff)
      else $error("nack flag set outside a transaction");

   // Bit counter stays within eight data bits plus the acknowledge bit.
   assert property (@(posedge clock) disable iff (reset)
      bit_ff <= ACK_BIT_INDEX)
      else $error("bit index out of range");

   // Idle always leaves the phase counters cleared for the next command.
   assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_IDLE |-> (tick_ff == 8'd0) && (bit_ff == 4'd0))
      else $error("counters not cleared in idle");

endmodule

`default_nettype wire
